// ===== sv/ltp_two_ring_histogram_assert.svh =====
// ----------------------------------------------------------------------------
// ltp_two_ring_histogram_assert.svh
// Assertion macros used by the queue of the two-ring LTP histogram RTL.
// ----------------------------------------------------------------------------
`ifndef LTP_TWO_RING_HISTOGRAM_ASSERT_SVH
`define LTP_TWO_RING_HISTOGRAM_ASSERT_SVH

// same-cycle implication, checked on clk, disabled in reset
`define LTP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LTP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/ltp_pkg.sv =====
// ----------------------------------------------------------------------------
// ltp_pkg
// Types, codes and the uniform-pattern table of the two-ring LTP histogram.
// ----------------------------------------------------------------------------
package ltp_pkg;

    localparam int FIFO_DEPTH = 8;
    localparam int LEVEL_BITS = $clog2(FIFO_DEPTH + 1);
    localparam int SIZE_BITS  = 14;

    localparam logic [5:0] NONUNIFORM = 6'd58;

    localparam logic [1:0] MODE_PUSH  = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_WIDTH     = 2'd1;
    localparam logic [1:0] REG_HEIGHT    = 2'd2;

    localparam logic KIND_PATTERN = 1'b0;
    localparam logic KIND_COUNT   = 1'b1;

    typedef enum logic [1:0] {
        OP_PATTERN,
        OP_READ,
        OP_CLEAR
    } ltp_op_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] pixel;
        logic [7:0] bin_index;
    } ltp_req_t;

    typedef struct packed {
        logic        kind;
        logic [5:0]  inner_above;
        logic [5:0]  inner_below;
        logic [5:0]  outer_above;
        logic [5:0]  outer_below;
        logic [15:0] bin_count;
    } ltp_rsp_t;

    typedef struct packed {
        logic [7:0]  threshold;
        logic [10:0] image_width;
        logic [12:0] image_height;
    } ltp_cfg_t;

    typedef struct packed {
        ltp_op_t        op;
        logic [3:0][5:0] idx;
        logic [7:0]     bin_index;
    } ltp_entry_t;

    typedef struct packed {
        logic                  empty;
        logic [LEVEL_BITS-1:0] level;
    } ltp_fifo_stat_t;

    typedef logic [5:0] uni_lut_t [256];

    function automatic uni_lut_t build_uni_lut();
        uni_lut_t   lut;
        int         rank;
        logic [7:0] x;
        logic [7:0] d;
        rank = 0;
        for (int v = 0; v < 256; v++)
        begin
            x = 8'(v);
            d = x ^ {x[0], x[7:1]};
            if ($countones(d) <= 2)
            begin
                lut[v] = 6'(rank);
                rank++;
            end
            else
            begin
                lut[v] = NONUNIFORM;
            end
        end
        return lut;
    endfunction

    localparam uni_lut_t UNI_LUT = build_uni_lut();

endpackage

// ===== sv/ltp_fifo.sv =====
// ----------------------------------------------------------------------------
// ltp_fifo
// Short queue of classified transactions between front end and histogram.
// ----------------------------------------------------------------------------
`include "ltp_two_ring_histogram_assert.svh"

module ltp_fifo (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  ltp_pkg::ltp_entry_t     push_entry,
    input  logic                    pop,
    output ltp_pkg::ltp_entry_t     head,
    output ltp_pkg::ltp_fifo_stat_t stat
);
    import ltp_pkg::*;

    localparam int PW = $clog2(FIFO_DEPTH);

    ltp_entry_t            fifo_reg [FIFO_DEPTH];
    logic [PW-1:0]         wr_ptr_reg, rd_ptr_reg;
    logic [LEVEL_BITS-1:0] level_reg, level_next;

    always_comb
    begin
        level_next = level_reg;
        if (push && !pop)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            level_reg <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign head       = fifo_reg[rd_ptr_reg];
    assign stat.empty = (level_reg == '0);
    assign stat.level = level_reg;

    `LTP_ASSERT_NOW(a_no_overflow, push && !pop,
        level_reg != LEVEL_BITS'(FIFO_DEPTH), "queue overflow")
    `LTP_ASSERT_NOW(a_no_underflow, pop, level_reg != '0, "queue underflow")
    `LTP_ASSERT_NEXT(a_level_up, push && !pop,
        level_reg == $past(level_reg) + 1'b1, "queue level did not advance")

endmodule

// ===== sv/ltp_front.sv =====
// ----------------------------------------------------------------------------
// ltp_front
// Raster tracking, line store, 5x5 window, ternary compare and uniform lookup.
// ----------------------------------------------------------------------------
module ltp_front #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    req_valid,
    output logic                    req_stall,
    input  ltp_pkg::ltp_req_t       req,
    input  ltp_pkg::ltp_cfg_t       cfg,
    input  ltp_pkg::ltp_fifo_stat_t fifo_stat,
    output logic                    push,
    output ltp_pkg::ltp_entry_t     push_entry
);
    import ltp_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RING_R [2][8] = '{'{1, 1, 2, 3, 3, 3, 2, 1}, '{0, 0, 2, 4, 4, 4, 2, 0}};
    localparam int RING_C [2][8] = '{'{2, 3, 3, 3, 2, 1, 1, 1}, '{2, 4, 4, 4, 2, 0, 0, 0}};

    logic [CW-1:0]        col_reg, col_next;
    logic [11:0]          row_reg, row_next;
    logic                 accept;
    logic                 emit;
    logic [SIZE_BITS-1:0] w_eff, col_inc;
    logic [12:0]          h_eff, row_inc;
    logic [LEVEL_BITS:0]  credit;

    logic [31:0]          ls_mem [MAX_WIDTH];
    logic [31:0]          rd_reg;

    logic                 s1_v_reg;
    ltp_op_t              s1_op_reg;
    logic                 s1_emit_reg;
    logic [7:0]           s1_pix_reg;
    logic [7:0]           s1_bin_reg;
    logic [CW-1:0]        s1_col_reg;
    ltp_op_t              op_in;

    logic                 s2_v_reg;
    ltp_op_t              s2_op_reg;
    logic [7:0]           s2_bin_reg;

    logic [7:0]           win_reg [5][5];
    logic [3:0][7:0]      code;

    assign credit    = (LEVEL_BITS+1)'(fifo_stat.level) + (LEVEL_BITS+1)'(s1_v_reg)
                     + (LEVEL_BITS+1)'(s2_v_reg);
    assign req_stall = (credit >= (LEVEL_BITS+1)'(FIFO_DEPTH));
    assign accept    = req_valid && !req_stall;

    always_comb
    begin
        if (cfg.image_width < 11'd5)
        begin
            w_eff = SIZE_BITS'(5);
        end
        else if (SIZE_BITS'(cfg.image_width) > SIZE_BITS'(MAX_WIDTH))
        begin
            w_eff = SIZE_BITS'(MAX_WIDTH);
        end
        else
        begin
            w_eff = SIZE_BITS'(cfg.image_width);
        end
        if (cfg.image_height < 13'd5)
        begin
            h_eff = 13'd5;
        end
        else if (cfg.image_height > 13'd4096)
        begin
            h_eff = 13'd4096;
        end
        else
        begin
            h_eff = cfg.image_height;
        end
    end

    assign col_inc = SIZE_BITS'(col_reg) + 1'b1;
    assign row_inc = 13'(row_reg) + 1'b1;
    assign emit    = (row_reg >= 12'd4) && (col_reg >= CW'(4));

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept && req.mode == MODE_CLEAR)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept && req.mode == MODE_PUSH)
        begin
            if (col_inc >= w_eff)
            begin
                col_next = '0;
                row_next = (row_inc >= h_eff) ? 12'd0 : row_inc[11:0];
            end
            else
            begin
                col_next = col_inc[CW-1:0];
            end
        end
    end

    always_comb
    begin
        case (req.mode)
            MODE_READ:  op_in = OP_READ;
            MODE_CLEAR: op_in = OP_CLEAR;
            default:    op_in = OP_PATTERN;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            for (int r = 0; r < 5; r++)
            begin
                for (int k = 0; k < 5; k++)
                begin
                    win_reg[r][k] <= '0;
                end
            end
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            s1_v_reg <= accept && (req.mode == MODE_PUSH || req.mode == MODE_READ
                                   || req.mode == MODE_CLEAR);
            s2_v_reg <= s1_v_reg && (s1_op_reg != OP_PATTERN || s1_emit_reg);
            if (s1_v_reg && s1_op_reg == OP_CLEAR)
            begin
                for (int r = 0; r < 5; r++)
                begin
                    for (int k = 0; k < 5; k++)
                    begin
                        win_reg[r][k] <= '0;
                    end
                end
            end
            else if (s1_v_reg && s1_op_reg == OP_PATTERN)
            begin
                for (int r = 0; r < 5; r++)
                begin
                    for (int k = 0; k < 4; k++)
                    begin
                        win_reg[r][k] <= win_reg[r][k+1];
                    end
                end
                for (int r = 0; r < 4; r++)
                begin
                    win_reg[r][4] <= rd_reg[8*r +: 8];
                end
                win_reg[4][4] <= s1_pix_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_op_reg   <= op_in;
        s1_emit_reg <= emit;
        s1_pix_reg  <= req.pixel;
        s1_bin_reg  <= req.bin_index;
        s1_col_reg  <= col_reg;
        s2_op_reg   <= s1_op_reg;
        s2_bin_reg  <= s1_bin_reg;
    end

    // line store: four rows packed per column, oldest row in the low byte
    always_ff @(posedge clk)
    begin
        if (accept && req.mode == MODE_PUSH)
        begin
            rd_reg <= ls_mem[col_reg];
        end
        if (s1_v_reg && s1_op_reg == OP_PATTERN)
        begin
            ls_mem[s1_col_reg] <= {s1_pix_reg, rd_reg[31:8]};
        end
    end

    always_comb
    begin
        code = '0;
        for (int g = 0; g < 2; g++)
        begin
            for (int k = 0; k < 8; k++)
            begin
                if ({1'b0, win_reg[RING_R[g][k]][RING_C[g][k]]}
                    > {1'b0, win_reg[2][2]} + {1'b0, cfg.threshold})
                begin
                    code[2*g][k] = 1'b1;
                end
                if ({1'b0, win_reg[RING_R[g][k]][RING_C[g][k]]} + {1'b0, cfg.threshold}
                    < {1'b0, win_reg[2][2]})
                begin
                    code[2*g+1][k] = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        push_entry.op        = s2_op_reg;
        push_entry.bin_index = s2_bin_reg;
        for (int g = 0; g < 4; g++)
        begin
            push_entry.idx[g] = UNI_LUT[code[g]];
        end
    end

    assign push = s2_v_reg;

endmodule

// ===== sv/ltp_back.sv =====
// ----------------------------------------------------------------------------
// ltp_back
// Saturating histogram of four groups, bin reads and clears, result register.
// ----------------------------------------------------------------------------
module ltp_back #(
    parameter int COUNT_BITS = 16,
    parameter int GROUP_BINS = 60
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  ltp_pkg::ltp_fifo_stat_t fifo_stat,
    input  ltp_pkg::ltp_entry_t     head,
    output logic                    pop,
    output logic                    rsp_valid,
    input  logic                    rsp_stall,
    output ltp_pkg::ltp_rsp_t       rsp
);
    import ltp_pkg::*;

    localparam int AW    = $clog2(GROUP_BINS);
    localparam int DEPTH = 2 ** AW;

    logic                  b1_v_reg;
    ltp_op_t               b1_op_reg;
    logic [3:0][5:0]       b1_idx_reg;
    logic [1:0]            b1_gsel_reg;
    logic                  b1_ok_reg;

    logic                  out_take, b1_done, wr_en, clr, load;
    logic [8:0]            b9, off;
    logic [1:0]            gsel;
    logic                  bin_ok;
    logic [AW-1:0]         addr0 [4];
    logic [COUNT_BITS-1:0] cur [4];
    logic [COUNT_BITS-1:0] inc [4];
    logic [31:0]           count_ext;

    logic                  rsp_valid_reg;
    ltp_rsp_t              rsp_reg, rsp_next;

    assign out_take = !rsp_valid_reg || !rsp_stall;
    assign b1_done  = b1_v_reg && (b1_op_reg == OP_CLEAR || out_take);
    assign pop      = !fifo_stat.empty && (!b1_v_reg || b1_done);
    assign wr_en    = b1_done && b1_op_reg == OP_PATTERN;
    assign clr      = b1_done && b1_op_reg == OP_CLEAR;
    assign load     = b1_v_reg && b1_op_reg != OP_CLEAR && out_take;

    always_comb
    begin
        b9     = {1'b0, head.bin_index};
        bin_ok = (b9 < 9'(4 * GROUP_BINS));
        if (b9 < 9'(GROUP_BINS))
        begin
            gsel = 2'd0;
            off  = b9;
        end
        else if (b9 < 9'(2 * GROUP_BINS))
        begin
            gsel = 2'd1;
            off  = b9 - 9'(GROUP_BINS);
        end
        else if (b9 < 9'(3 * GROUP_BINS))
        begin
            gsel = 2'd2;
            off  = b9 - 9'(2 * GROUP_BINS);
        end
        else
        begin
            gsel = 2'd3;
            off  = b9 - 9'(3 * GROUP_BINS);
        end
        for (int g = 0; g < 4; g++)
        begin
            addr0[g] = (head.op == OP_PATTERN) ? head.idx[g][AW-1:0] : off[AW-1:0];
        end
    end

    for (genvar g = 0; g < 4; g++)
    begin : g_grp
        logic [COUNT_BITS-1:0] hist_mem [DEPTH];
        logic [COUNT_BITS-1:0] rdata_reg;
        logic [AW-1:0]         addr_reg;
        logic [DEPTH-1:0]      vld_reg;
        logic                  fwd_v_reg;
        logic [AW-1:0]         fwd_a_reg;
        logic [COUNT_BITS-1:0] fwd_d_reg;

        always_ff @(posedge clk)
        begin
            if (pop)
            begin
                rdata_reg <= hist_mem[addr0[g]];
                addr_reg  <= addr0[g];
            end
            if (wr_en)
            begin
                hist_mem[addr_reg] <= inc[g];
                fwd_a_reg          <= addr_reg;
                fwd_d_reg          <= inc[g];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg   <= '0;
                fwd_v_reg <= 1'b0;
            end
            else if (clr)
            begin
                vld_reg   <= '0;
                fwd_v_reg <= 1'b0;
            end
            else if (wr_en)
            begin
                vld_reg[addr_reg] <= 1'b1;
                fwd_v_reg         <= 1'b1;
            end
        end

        // write of the previous edge is not yet in rdata_reg
        assign cur[g] = (fwd_v_reg && fwd_a_reg == addr_reg) ? fwd_d_reg
                      : (vld_reg[addr_reg] ? rdata_reg : '0);
        assign inc[g] = (cur[g] == {COUNT_BITS{1'b1}}) ? cur[g] : cur[g] + 1'b1;
    end

    assign count_ext = 32'(cur[b1_gsel_reg]);

    always_comb
    begin
        rsp_next = '0;
        if (b1_op_reg == OP_READ)
        begin
            rsp_next.kind      = KIND_COUNT;
            rsp_next.bin_count = b1_ok_reg ? count_ext[15:0] : 16'd0;
        end
        else
        begin
            rsp_next.kind        = KIND_PATTERN;
            rsp_next.inner_above = b1_idx_reg[0];
            rsp_next.inner_below = b1_idx_reg[1];
            rsp_next.outer_above = b1_idx_reg[2];
            rsp_next.outer_below = b1_idx_reg[3];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_v_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                b1_v_reg <= 1'b1;
            end
            else if (b1_done)
            begin
                b1_v_reg <= 1'b0;
            end
            if (load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            b1_op_reg   <= head.op;
            b1_idx_reg  <= head.idx;
            b1_gsel_reg <= gsel;
            b1_ok_reg   <= bin_ok;
        end
        if (load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== sv/ltp_two_ring_histogram.sv =====
// ----------------------------------------------------------------------------
// ltp_two_ring_histogram
// Two-ring local ternary pattern codes with a saturating uniform histogram.
// ----------------------------------------------------------------------------
//  channel  | signals                          | carries
//  request  | req_valid, req_stall, req        | mode, pixel, bin_index
//  result   | rsp_valid, rsp_stall, rsp        | kind, four indices, bin_count
//  config   | psel/penable/pwrite/paddr/pwdata | threshold, image_width, height
//
//  One transaction per cycle sustained while rsp_stall stays low; a transaction
//  passes the front-end s1 and s2 registers to the queue, then the histogram
//  read-modify-write through b1, and its result is registered in rsp_reg.
//  Histogram valid bits clear at reset and on a clear, so no sweep is needed.
//  req_stall rises only when the queue level plus the s1 and s2 entries reach 8.
//  The line store holds no reset; border handling keeps stale data unused.
// ----------------------------------------------------------------------------
module ltp_two_ring_histogram #(
    parameter int MAX_WIDTH  = 1024,
    parameter int COUNT_BITS = 16,
    parameter int GROUP_BINS = 60
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  ltp_pkg::ltp_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output ltp_pkg::ltp_rsp_t rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import ltp_pkg::*;

    ltp_cfg_t       cfg_reg;
    ltp_fifo_stat_t fifo_stat;
    ltp_entry_t     push_entry, head;
    logic           push, pop;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold    <= 8'd5;
            cfg_reg.image_width  <= 11'd64;
            cfg_reg.image_height <= 13'd64;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (paddr[3:2])
                REG_THRESHOLD: cfg_reg.threshold    <= pwdata[7:0];
                REG_WIDTH:     cfg_reg.image_width  <= pwdata[10:0];
                REG_HEIGHT:    cfg_reg.image_height <= pwdata[12:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_THRESHOLD: prdata = 32'(cfg_reg.threshold);
            REG_WIDTH:     prdata = 32'(cfg_reg.image_width);
            REG_HEIGHT:    prdata = 32'(cfg_reg.image_height);
            default:       prdata = '0;
        endcase
    end

    ltp_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .cfg        (cfg_reg),
        .fifo_stat  (fifo_stat),
        .push       (push),
        .push_entry (push_entry)
    );

    ltp_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .stat       (fifo_stat)
    );

    ltp_back #(
        .COUNT_BITS (COUNT_BITS),
        .GROUP_BINS (GROUP_BINS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .fifo_stat (fifo_stat),
        .head      (head),
        .pop       (pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule
